// ===== rtl/core/hashed_timer_wheel_unit_macros.svh =====
// Assertion macros for the timer wheel unit.
`ifndef HASHED_TIMER_WHEEL_UNIT_MACROS_SVH
`define HASHED_TIMER_WHEEL_UNIT_MACROS_SVH

// Plain check, sampled on clk, off during reset.
`define HTW_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication, sampled on clk, off during reset.
`define HTW_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/htw_pkg.sv =====
// Shared constants and types for the hashed timer wheel.
`timescale 1ns / 1ps
`default_nettype none
package htw_pkg;

	localparam int BUCKETS    = 16;
	localparam int SLOTS      = 4;
	localparam int TICK_UNITS = 16;
	localparam int TOTAL      = BUCKETS * SLOTS;

	localparam int TIME_W = 48;
	localparam int TAG_W  = 32;
	localparam int WAIT_W = 5;
	localparam int MODE_W = 2;
	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int IDX_W  = $clog2(TOTAL);
	localparam int CNT_W  = $clog2(TOTAL + 1);
	localparam int STEP_W = $clog2(BUCKETS + 1);
	localparam int TICK_W = $clog2(TICK_UNITS);

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD     = 2'd0,
		MODE_CANCEL  = 2'd1,
		MODE_ADVANCE = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic check;
		logic finish;
	} htw_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  scan_done;
		logic  slot_live;
	} htw_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/htw_ctrl.sv =====
// Controller state machine sequencing add, cancel, clear and advance scans.
`timescale 1ns / 1ps
`default_nettype none
module htw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  htw_pkg::htw_sts_t sts,
	output htw_pkg::htw_cmd_t cmd,
	output logic              busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_CHECK,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.mode == htw_pkg::MODE_ADVANCE) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_FINISH;
				end else if (sts.slot_live) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_SCAN;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

// ===== rtl/core/htw_datapath.sv =====
// Datapath: timer memory, slot valid bits, wheel head, time base and result register.
`timescale 1ns / 1ps
`default_nettype none
module htw_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  htw_pkg::htw_cmd_t                   cmd,
	output htw_pkg::htw_sts_t                   sts,
	input  logic [htw_pkg::MODE_W-1:0]          mode,
	input  logic [htw_pkg::TIME_W-1:0]          delay,
	input  logic [htw_pkg::TAG_W-1:0]           type_tag,
	input  logic [htw_pkg::TAG_W-1:0]           data_handle,
	input  logic [htw_pkg::BKT_W-1:0]           cancel_bucket,
	input  logic [htw_pkg::SLOT_W-1:0]          cancel_slot,
	input  logic                                id_valid,
	input  logic [htw_pkg::TIME_W-1:0]          now,
	input  logic                                cfg_we,
	input  logic [htw_pkg::TIME_W-1:0]          cfg_data,
	output logic                                result_valid,
	output logic                                ok,
	output logic [htw_pkg::BKT_W-1:0]           id_bucket,
	output logic [htw_pkg::SLOT_W-1:0]          id_slot,
	output logic                                expired,
	output logic [htw_pkg::TIME_W-1:0]          expiry_time,
	output logic [htw_pkg::TAG_W-1:0]           type_out,
	output logic [htw_pkg::TAG_W-1:0]           data_out,
	output logic [htw_pkg::WAIT_W-1:0]          wait_time,
	output logic                                last
);

	localparam int WAIT_MAX = (1 << htw_pkg::WAIT_W) - 1;

	typedef struct packed {
		logic [htw_pkg::TIME_W-1:0] expiry;
		logic [htw_pkg::TAG_W-1:0]  tag;
		logic [htw_pkg::TAG_W-1:0]  handle;
	} entry_t;

	typedef struct packed {
		logic                       ok;
		logic [htw_pkg::BKT_W-1:0]  bkt;
		logic [htw_pkg::SLOT_W-1:0] slot;
		logic                       expired;
		logic [htw_pkg::TIME_W-1:0] expiry;
		logic [htw_pkg::TAG_W-1:0]  tag;
		logic [htw_pkg::TAG_W-1:0]  handle;
		logic [htw_pkg::WAIT_W-1:0] wait_tm;
		logic                       last;
	} res_t;

	// timer memory, one entry per slot
	entry_t mem [htw_pkg::TOTAL];
	entry_t rd_q;

	// captured transaction
	htw_pkg::mode_t              mode_q;
	logic [htw_pkg::TIME_W-1:0]  delay_q;
	logic [htw_pkg::TAG_W-1:0]   tag_q;
	logic [htw_pkg::TAG_W-1:0]   handle_q;
	logic [htw_pkg::BKT_W-1:0]   cbkt_q;
	logic [htw_pkg::SLOT_W-1:0]  cslot_q;
	logic                        idv_q;
	logic [htw_pkg::TIME_W-1:0]  now_q;

	// wheel state
	logic [htw_pkg::TOTAL-1:0]   valid_q;
	logic [htw_pkg::BKT_W-1:0]   head_q;
	logic [htw_pkg::TIME_W-1:0]  ct_q;
	logic [htw_pkg::IDX_W-1:0]   idx_q;
	logic [htw_pkg::CNT_W-1:0]   cnt_q;
	logic [htw_pkg::WAIT_W-1:0]  wait_q;
	logic                        pend_vld_q;
	res_t                        pend_q;
	logic                        result_valid_q;
	res_t                        res_q;

	// add path
	logic [htw_pkg::BKT_W-1:0]   add_bkt;
	logic [htw_pkg::SLOT_W-1:0]  add_slot;
	logic                        add_found;
	logic [htw_pkg::TIME_W:0]    add_sum;
	logic [htw_pkg::TIME_W-1:0]  add_exp;
	logic [htw_pkg::IDX_W-1:0]   add_idx;

	// cancel path
	logic                        cancel_ok;
	logic [htw_pkg::IDX_W-1:0]   cancel_idx;

	// advance path
	logic [htw_pkg::TIME_W-1:0]  elapsed;
	logic [htw_pkg::TIME_W-1:0]  elapsed_ticks;
	logic [htw_pkg::STEP_W-1:0]  step_n;
	logic [htw_pkg::TIME_W-1:0]  wait_full;
	logic [htw_pkg::WAIT_W-1:0]  wait_d;
	logic                        chk_hit;

	res_t                        res_d;
	logic                        res_fire;
	res_t                        hit_rec;

	always_comb begin
		add_bkt   = head_q + delay_q[htw_pkg::TICK_W +: htw_pkg::BKT_W];
		add_found = 1'b0;
		add_slot  = '0;
		for (int s = 0; s < htw_pkg::SLOTS; s++) begin
			if (!add_found && !valid_q[{add_bkt, htw_pkg::SLOT_W'(s)}]) begin
				add_found = 1'b1;
				add_slot  = htw_pkg::SLOT_W'(s);
			end
		end
		add_idx = {add_bkt, add_slot};
		add_sum = {1'b0, ct_q} + {1'b0, delay_q};
		add_exp = add_sum[htw_pkg::TIME_W] ? '1 : add_sum[htw_pkg::TIME_W-1:0];
	end

	assign cancel_idx = {cbkt_q, cslot_q};
	assign cancel_ok  = idv_q && (32'(cbkt_q) < htw_pkg::BUCKETS)
		&& (32'(cslot_q) < htw_pkg::SLOTS);

	always_comb begin
		elapsed       = now_q - ct_q;
		elapsed_ticks = elapsed >> htw_pkg::TICK_W;
		if (elapsed_ticks >= htw_pkg::TIME_W'(htw_pkg::BUCKETS)) begin
			step_n = htw_pkg::STEP_W'(htw_pkg::BUCKETS);
		end else begin
			step_n = elapsed_ticks[htw_pkg::STEP_W-1:0];
		end
		if (elapsed < htw_pkg::TIME_W'(htw_pkg::TICK_UNITS)) begin
			wait_full = htw_pkg::TIME_W'(htw_pkg::TICK_UNITS) - elapsed;
		end else begin
			wait_full = htw_pkg::TIME_W'(htw_pkg::TICK_UNITS);
		end
		if (wait_full > htw_pkg::TIME_W'(WAIT_MAX)) begin
			wait_d = htw_pkg::WAIT_W'(WAIT_MAX);
		end else begin
			wait_d = wait_full[htw_pkg::WAIT_W-1:0];
		end
	end

	assign chk_hit = (rd_q.expiry <= now_q);

	always_comb begin
		hit_rec         = '0;
		hit_rec.bkt     = idx_q[htw_pkg::IDX_W-1:htw_pkg::SLOT_W];
		hit_rec.slot    = idx_q[htw_pkg::SLOT_W-1:0];
		hit_rec.expired = 1'b1;
		hit_rec.expiry  = rd_q.expiry;
		hit_rec.tag     = rd_q.tag;
		hit_rec.handle  = rd_q.handle;
	end

	always_comb begin
		res_fire = 1'b0;
		res_d    = '0;
		if (cmd.exec) begin
			case (mode_q)
				htw_pkg::MODE_ADD: begin
					res_fire   = 1'b1;
					res_d.last = 1'b1;
					if (add_found) begin
						res_d.ok     = 1'b1;
						res_d.bkt    = add_bkt;
						res_d.slot   = add_slot;
						res_d.expiry = add_exp;
					end
				end
				htw_pkg::MODE_CANCEL, htw_pkg::MODE_CLEAR: begin
					res_fire   = 1'b1;
					res_d.last = 1'b1;
				end
				default: begin
					res_fire = 1'b0;
				end
			endcase
		end
		if (cmd.check && chk_hit && pend_vld_q) begin
			res_fire = 1'b1;
			res_d    = pend_q;
		end
		if (cmd.finish) begin
			res_fire = 1'b1;
			if (pend_vld_q) begin
				res_d = pend_q;
			end
			res_d.wait_tm = wait_q;
			res_d.last    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			head_q         <= '0;
			ct_q           <= '0;
			idx_q          <= '0;
			cnt_q          <= '0;
			wait_q         <= '0;
			pend_vld_q     <= 1'b0;
			pend_q         <= '0;
			result_valid_q <= 1'b0;
			res_q          <= '0;
		end else begin
			if (cfg_we) begin
				ct_q <= cfg_data;
			end
			if (cmd.exec) begin
				case (mode_q)
					htw_pkg::MODE_ADD: begin
						if (add_found) begin
							valid_q[add_idx] <= 1'b1;
						end
					end
					htw_pkg::MODE_CANCEL: begin
						if (cancel_ok) begin
							valid_q[cancel_idx] <= 1'b0;
						end
					end
					htw_pkg::MODE_CLEAR: begin
						valid_q <= '0;
						head_q  <= '0;
					end
					htw_pkg::MODE_ADVANCE: begin
						if (step_n != '0) begin
							ct_q   <= now_q;
							head_q <= head_q + step_n[htw_pkg::BKT_W-1:0];
						end
						idx_q      <= {head_q, htw_pkg::SLOT_W'(0)};
						cnt_q      <= htw_pkg::CNT_W'(step_n * htw_pkg::SLOTS);
						wait_q     <= wait_d;
						pend_vld_q <= 1'b0;
					end
					default: begin
						head_q <= head_q;
					end
				endcase
			end
			if (cmd.scan && (cnt_q != '0) && !valid_q[idx_q]) begin
				idx_q <= idx_q + htw_pkg::IDX_W'(1);
				cnt_q <= cnt_q - htw_pkg::CNT_W'(1);
			end
			if (cmd.check) begin
				idx_q <= idx_q + htw_pkg::IDX_W'(1);
				cnt_q <= cnt_q - htw_pkg::CNT_W'(1);
				if (chk_hit) begin
					valid_q[idx_q] <= 1'b0;
					pend_vld_q     <= 1'b1;
					pend_q         <= hit_rec;
				end
			end
			if (cmd.finish) begin
				pend_vld_q <= 1'b0;
			end
			result_valid_q <= res_fire;
			if (res_fire) begin
				res_q <= res_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= htw_pkg::mode_t'(mode);
			delay_q  <= delay;
			tag_q    <= type_tag;
			handle_q <= data_handle;
			cbkt_q   <= cancel_bucket;
			cslot_q  <= cancel_slot;
			idv_q    <= id_valid;
			now_q    <= now;
		end
		if (cmd.exec && (mode_q == htw_pkg::MODE_ADD) && add_found) begin
			mem[add_idx] <= {add_exp, tag_q, handle_q};
		end
		rd_q <= mem[idx_q];
	end

	assign sts.mode      = mode_q;
	assign sts.scan_done = (cnt_q == '0);
	assign sts.slot_live = valid_q[idx_q];

	assign result_valid = result_valid_q;
	assign ok           = res_q.ok;
	assign id_bucket    = res_q.bkt;
	assign id_slot      = res_q.slot;
	assign expired      = res_q.expired;
	assign expiry_time  = res_q.expiry;
	assign type_out     = res_q.tag;
	assign data_out     = res_q.handle;
	assign wait_time    = res_q.wait_tm;
	assign last         = res_q.last;

endmodule
`default_nettype wire

// ===== rtl/core/hashed_timer_wheel_unit.sv =====
// Top level of the hashed timer wheel: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_timer_wheel_unit_macros.svh"
// A transaction is taken when start is high and busy is low. Add, cancel and
// clear give one result, registered from the execute state, and busy is high
// for one cycle, so no new transaction is taken while one is in flight.
// Advance walks the slots of the passed buckets through the single read port
// of the timer memory: a free slot passes through the scan state only, an
// occupied slot through scan and then check, and a finish state closes the
// walk; a full wheel has 64 slots. Each result is shown for exactly one cycle
// with result_valid high; the receiver cannot stall, so it must take every
// result as it comes. The final result of every transaction has last set.
// cfg_data may be written only while busy is low.
module hashed_timer_wheel_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [htw_pkg::MODE_W-1:0]  mode,
	input  logic [htw_pkg::TIME_W-1:0]  delay,
	input  logic [htw_pkg::TAG_W-1:0]   type_tag,
	input  logic [htw_pkg::TAG_W-1:0]   data_handle,
	input  logic [htw_pkg::BKT_W-1:0]   cancel_bucket,
	input  logic [htw_pkg::SLOT_W-1:0]  cancel_slot,
	input  logic                        id_valid,
	input  logic [htw_pkg::TIME_W-1:0]  now,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [htw_pkg::TIME_W-1:0]  cfg_data,
	output logic                        result_valid,
	output logic                        ok,
	output logic [htw_pkg::BKT_W-1:0]   id_bucket,
	output logic [htw_pkg::SLOT_W-1:0]  id_slot,
	output logic                        expired,
	output logic [htw_pkg::TIME_W-1:0]  expiry_time,
	output logic [htw_pkg::TAG_W-1:0]   type_out,
	output logic [htw_pkg::TAG_W-1:0]   data_out,
	output logic [htw_pkg::WAIT_W-1:0]  wait_time,
	output logic                        last
);

	htw_pkg::htw_cmd_t cmd;
	htw_pkg::htw_sts_t sts;
	logic              cfg_we;

	assign cfg_ready = ~busy;
	assign cfg_we    = cfg_valid & cfg_ready;

	htw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	htw_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.delay         (delay),
		.type_tag      (type_tag),
		.data_handle   (data_handle),
		.cancel_bucket (cancel_bucket),
		.cancel_slot   (cancel_slot),
		.id_valid      (id_valid),
		.now           (now),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.ok            (ok),
		.id_bucket     (id_bucket),
		.id_slot       (id_slot),
		.expired       (expired),
		.expiry_time   (expiry_time),
		.type_out      (type_out),
		.data_out      (data_out),
		.wait_time     (wait_time),
		.last          (last)
	);

	`HTW_IMPLY(a_result_follows_work, result_valid, $past(busy), "result without a transaction in flight")
	`HTW_IMPLY(a_more_results_busy, result_valid && !last, busy, "non-final result after the transaction ended")
	`HTW_CHECK(a_ok_not_expired, !(result_valid && ok && expired), "add success flagged as expiry")

endmodule
`default_nettype wire
